// File: sv/jse_pkg.sv
// Shared types, constants and helpers for the JSON string escaper.
package jse_pkg;

   localparam int unsigned CAP_W      = 13;
   localparam int unsigned LEN_W      = 12;
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned IDX_W      = 3;
   localparam int unsigned QUEUE_AW   = 2;
   localparam int unsigned QUEUE_CW   = QUEUE_AW + 1;
   localparam int unsigned QUEUE_DEPTH = 1 << QUEUE_AW;

   localparam logic [CAP_W-1:0]  CAP_RESET  = 13'd1024;
   localparam logic [CAP_W-1:0]  CAP_MAX    = 13'd4096;
   localparam logic [BYTE_W-1:0] CTRL_LIMIT = 8'h20;

   localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
   localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0a;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0d;
   localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
   localparam logic [BYTE_W-1:0] CH_BSL   = 8'h5c;
   localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CH_LOW_A = 8'h61;
   localparam logic [BYTE_W-1:0] CH_LOW_N = 8'h6e;
   localparam logic [BYTE_W-1:0] CH_LOW_R = 8'h72;
   localparam logic [BYTE_W-1:0] CH_LOW_T = 8'h74;
   localparam logic [BYTE_W-1:0] CH_LOW_U = 8'h75;

   typedef enum logic [1:0] {
      KIND_PLAIN,
      KIND_PAIR,
      KIND_UNI,
      KIND_NUL
   } jse_kind_type;

   typedef struct packed {
      jse_kind_type      kind;
      logic [BYTE_W-1:0] ch;
      logic [LEN_W-1:0]  len;
   } jse_desc_type;

   function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] nib);
      logic [BYTE_W-1:0] d;
      if (nib < 4'd10) begin
         d = CH_ZERO + {4'd0, nib};
      end else begin
         d = CH_LOW_A + {4'd0, nib - 4'd10};
      end
      return d;
   endfunction

   function automatic logic [IDX_W-1:0] last_idx(input jse_kind_type kind);
      logic [IDX_W-1:0] r;
      unique case (kind)
         KIND_PAIR: r = 3'd1;
         KIND_UNI:  r = 3'd5;
         default:   r = 3'd0;
      endcase
      return r;
   endfunction

endpackage

// File: sv/jse_front.sv
// Front end: capacity register, byte classification and write count tracking.
module jse_front import jse_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CAP_W-1:0]  csr_capacity,
   input  logic              push,
   output logic              full,
   input  logic [BYTE_W-1:0] req_in_byte,
   input  logic              q_full,
   output logic              q_push,
   output jse_desc_type      q_desc
);

   logic [CAP_W-1:0] capacity_ff, capacity_in;
   logic [LEN_W-1:0] write_count_ff, write_count_in;
   logic             stopped_ff, stopped_in;

   logic [CAP_W-1:0] cap_eff;
   logic [CAP_W-1:0] wc_ext;
   logic             room_any;
   logic             room_uni;
   logic             accept;
   logic [IDX_W-1:0] n_bytes;

   assign csr_ready = 1'b1;
   assign full      = q_full;
   assign accept    = push && !q_full;

   assign cap_eff  = (capacity_ff > CAP_MAX) ? CAP_MAX : capacity_ff;
   assign wc_ext   = {1'b0, write_count_ff};
   assign room_any = (wc_ext + 13'd2) < cap_eff;
   assign room_uni = (wc_ext + 13'd6) < cap_eff;

   always_comb begin
      capacity_in    = capacity_ff;
      write_count_in = write_count_ff;
      stopped_in     = stopped_ff;
      q_push         = 1'b0;
      q_desc.kind    = KIND_PLAIN;
      q_desc.ch      = req_in_byte;
      q_desc.len     = '0;
      n_bytes        = 3'd1;
      if (csr_valid) begin
         capacity_in = csr_capacity;
      end
      unique case (req_in_byte)
         CH_QUOTE: begin q_desc.kind = KIND_PAIR; q_desc.ch = CH_QUOTE; n_bytes = 3'd2; end
         CH_BSL:   begin q_desc.kind = KIND_PAIR; q_desc.ch = CH_BSL;   n_bytes = 3'd2; end
         CH_LF:    begin q_desc.kind = KIND_PAIR; q_desc.ch = CH_LOW_N; n_bytes = 3'd2; end
         CH_CR:    begin q_desc.kind = KIND_PAIR; q_desc.ch = CH_LOW_R; n_bytes = 3'd2; end
         CH_TAB:   begin q_desc.kind = KIND_PAIR; q_desc.ch = CH_LOW_T; n_bytes = 3'd2; end
         default: begin
            if (req_in_byte < CTRL_LIMIT) begin
               q_desc.kind = KIND_UNI;
               n_bytes     = 3'd6;
            end
         end
      endcase
      if (accept) begin
         priority if (req_in_byte == CH_NUL) begin
            q_desc.kind    = KIND_NUL;
            q_desc.ch      = CH_NUL;
            q_desc.len     = write_count_ff;
            q_push         = 1'b1;
            write_count_in = '0;
            stopped_in     = 1'b0;
         end else if (stopped_ff) begin
            q_push = 1'b0;
         end else if (!room_any) begin
            stopped_in = 1'b1;
         end else if ((q_desc.kind == KIND_UNI) && !room_uni) begin
            stopped_in = 1'b1;
         end else begin
            q_push         = 1'b1;
            write_count_in = write_count_ff + {{(LEN_W-IDX_W){1'b0}}, n_bytes};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff    <= CAP_RESET;
         write_count_ff <= '0;
         stopped_ff     <= 1'b0;
      end else begin
         capacity_ff    <= capacity_in;
         write_count_ff <= write_count_in;
         stopped_ff     <= stopped_in;
      end
   end

endmodule

// File: sv/jse_queue.sv
// Short descriptor queue between the front and back ends.
module jse_queue import jse_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         q_push,
   input  jse_desc_type q_wdata,
   output logic         q_full,
   input  logic         q_pop,
   output jse_desc_type q_rdata,
   output logic         q_empty
);

   jse_desc_type         entries_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]  count_ff, count_in;
   logic                 do_push, do_pop;

   assign q_full  = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign q_empty = (count_ff == '0);
   assign q_rdata = entries_ff[rd_ptr_ff];
   assign do_push = q_push && !q_full;
   assign do_pop  = q_pop && !q_empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= q_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: sv/jse_back.sv
// Back end: expand each descriptor into its escaped output words.
module jse_back import jse_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  jse_desc_type      q_rdata,
   input  logic              q_empty,
   output logic              q_pop,
   output logic              empty,
   input  logic              pop,
   output logic [BYTE_W-1:0] rsp_out_byte,
   output logic              rsp_run_last,
   output logic              rsp_string_done,
   output logic [LEN_W-1:0]  rsp_written_length
);

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             take;

   assign empty = q_empty;
   assign take  = pop && !q_empty;

   assign rsp_run_last       = (idx_ff == last_idx(q_rdata.kind));
   assign rsp_string_done    = (q_rdata.kind == KIND_NUL);
   assign rsp_written_length = rsp_string_done ? q_rdata.len : '0;
   assign q_pop              = take && rsp_run_last;

   always_comb begin
      rsp_out_byte = q_rdata.ch;
      unique case (q_rdata.kind)
         KIND_PLAIN: rsp_out_byte = q_rdata.ch;
         KIND_PAIR:  rsp_out_byte = (idx_ff == 3'd0) ? CH_BSL : q_rdata.ch;
         KIND_UNI: begin
            unique case (idx_ff)
               3'd0:    rsp_out_byte = CH_BSL;
               3'd1:    rsp_out_byte = CH_LOW_U;
               3'd2:    rsp_out_byte = CH_ZERO;
               3'd3:    rsp_out_byte = CH_ZERO;
               3'd4:    rsp_out_byte = hex_digit(q_rdata.ch[7:4]);
               default: rsp_out_byte = hex_digit(q_rdata.ch[3:0]);
            endcase
         end
         KIND_NUL:   rsp_out_byte = CH_NUL;
      endcase
   end

   always_comb begin
      idx_in = idx_ff;
      if (take) begin
         idx_in = rsp_run_last ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

// File: sv/json_string_escape_core.sv
// Top level of the JSON string escaper: front end, descriptor queue, back end.
// One source byte is taken per cycle while the four-entry descriptor queue has
// room; the front end classifies it against the write count in that cycle.
// The back end gives one result word per cycle while popped: plain bytes and
// the NUL take one word, two-byte escapes two and \u00XX escapes six, so the
// sustained input rate is one byte per cycle for plain text and is set by the
// expansion counter while escapes drain. The capacity port is always ready.
module json_string_escape_core import jse_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CAP_W-1:0]  csr_capacity,
   input  logic              push,
   output logic              full,
   input  logic [BYTE_W-1:0] req_in_byte,
   output logic              empty,
   input  logic              pop,
   output logic [BYTE_W-1:0] rsp_out_byte,
   output logic              rsp_run_last,
   output logic              rsp_string_done,
   output logic [LEN_W-1:0]  rsp_written_length
);

   logic         q_full, q_empty, q_push, q_pop;
   jse_desc_type q_wdata, q_rdata;

   jse_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_capacity (csr_capacity),
      .push         (push),
      .full         (full),
      .req_in_byte  (req_in_byte),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_desc       (q_wdata)
   );

   jse_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_wdata (q_wdata),
      .q_full  (q_full),
      .q_pop   (q_pop),
      .q_rdata (q_rdata),
      .q_empty (q_empty)
   );

   jse_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_rdata            (q_rdata),
      .q_empty            (q_empty),
      .q_pop              (q_pop),
      .empty              (empty),
      .pop                (pop),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_run_last       (rsp_run_last),
      .rsp_string_done    (rsp_string_done),
      .rsp_written_length (rsp_written_length)
   );

endmodule

// File: tb/sv/json_string_escape_core_checker.sv
`timescale 1ns / 100ps
// Checker for the JSON string escaper: predicts escaped words and compares them on pop.
module json_string_escape_core_checker import jse_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [CAP_W-1:0]  csr_capacity,
   input  logic              push,
   input  logic              full,
   input  logic [BYTE_W-1:0] req_in_byte,
   input  logic              empty,
   input  logic              pop,
   input  logic [BYTE_W-1:0] rsp_out_byte,
   input  logic              rsp_run_last,
   input  logic              rsp_string_done,
   input  logic [LEN_W-1:0]  rsp_written_length,
   output int                fail_count,
   output int                words_owed
);

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              run_last;
      logic              string_done;
      logic [LEN_W-1:0]  written_length;
   } escaped_word_type;

   escaped_word_type owed_words[$];
   logic [CAP_W-1:0] capacity    = CAP_RESET;
   logic [LEN_W-1:0] write_count = '0;
   logic             stopped     = 1'b0;
   int               mismatches  = 0;

   assign fail_count = mismatches;

   function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
      return (nib < 4'd10) ? (CH_ZERO + nib) : (CH_LOW_A + nib - 8'd10);
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   task automatic queue_escape(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] seq [6];
      int unsigned       n;
      int unsigned       room;
      escaped_word_type  w;
      room = 32'((capacity > CAP_MAX) ? CAP_MAX : capacity);
      n = 0;
      if (b == CH_NUL) begin
         w = '{CH_NUL, 1'b1, 1'b1, write_count};
         owed_words.push_back(w);
         write_count = '0;
         stopped = 1'b0;
      end else if (!stopped) begin
         if (write_count + 2 >= room) begin
            stopped = 1'b1;
         end else begin
            seq[0] = CH_BSL;
            n = 2;
            case (b)
               CH_QUOTE, CH_BSL: seq[1] = b;
               CH_LF:            seq[1] = CH_LOW_N;
               CH_CR:            seq[1] = CH_LOW_R;
               CH_TAB:           seq[1] = CH_LOW_T;
               default: begin
                  if (b >= CTRL_LIMIT) begin
                     seq[0] = b;
                     n = 1;
                  end else if (write_count + 6 >= room) begin
                     stopped = 1'b1;
                     n = 0;
                  end else begin
                     seq[1] = CH_LOW_U;
                     seq[2] = CH_ZERO;
                     seq[3] = CH_ZERO;
                     seq[4] = hex_char(b[7:4]);
                     seq[5] = hex_char(b[3:0]);
                     n = 6;
                  end
               end
            endcase
            for (int k = 0; k < n; k++) begin
               w = '{seq[k], (k == n - 1), 1'b0, {LEN_W{1'b0}}};
               owed_words.push_back(w);
            end
            write_count = LEN_W'(write_count + n);
         end
      end
   endtask

   always @(posedge clock) begin : watch
      escaped_word_type want;
      if (reset) begin
         owed_words.delete();
         capacity = CAP_RESET;
         write_count = '0;
         stopped = 1'b0;
      end else begin
         if (pop && !empty) begin
            if (owed_words.size() == 0) begin
               $error("unexpected result word: out_byte 0x%0h", rsp_out_byte);
               mismatches++;
            end else begin
               want = owed_words.pop_front();
               check_field("out_byte", want.out_byte, rsp_out_byte);
               check_field("run_last", want.run_last, rsp_run_last);
               check_field("string_done", want.string_done, rsp_string_done);
               check_field("written_length", want.written_length, rsp_written_length);
            end
         end
         if (csr_valid && csr_ready) begin
            capacity = csr_capacity;
         end
         if (push && !full) begin
            queue_escape(req_in_byte);
         end
      end
      words_owed = owed_words.size();
   end

endmodule

// File: tb/sv/json_string_escape_core_test.sv
`timescale 1ns / 100ps
// Testbench top for the JSON string escaper: stimulus, pacing of both sides and verdict.
module json_string_escape_core_test;
   import jse_pkg::*;

   logic              clock        = 1'b0;
   logic              reset        = 1'b1;
   logic              csr_valid    = 1'b0;
   logic              csr_ready;
   logic [CAP_W-1:0]  csr_capacity = CAP_RESET;
   logic              push         = 1'b0;
   logic              full;
   logic [BYTE_W-1:0] req_in_byte  = '0;
   logic              empty;
   logic              pop          = 1'b0;
   logic [BYTE_W-1:0] rsp_out_byte;
   logic              rsp_run_last;
   logic              rsp_string_done;
   logic [LEN_W-1:0]  rsp_written_length;

   int   fail_count;
   int   words_owed;
   int   bytes_sent = 0;
   int   rsp_gap    = 0;
   logic rsp_hold   = 1'b0;
   logic quick      = 1'b0;

   logic [BYTE_W-1:0] pair_chars [5] = '{CH_QUOTE, CH_BSL, CH_LF, CH_CR, CH_TAB};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   json_string_escape_core u_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_capacity       (csr_capacity),
      .push               (push),
      .full               (full),
      .req_in_byte        (req_in_byte),
      .empty              (empty),
      .pop                (pop),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_run_last       (rsp_run_last),
      .rsp_string_done    (rsp_string_done),
      .rsp_written_length (rsp_written_length)
   );

   json_string_escape_core_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_capacity       (csr_capacity),
      .push               (push),
      .full               (full),
      .req_in_byte        (req_in_byte),
      .empty              (empty),
      .pop                (pop),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_run_last       (rsp_run_last),
      .rsp_string_done    (rsp_string_done),
      .rsp_written_length (rsp_written_length),
      .fail_count         (fail_count),
      .words_owed         (words_owed)
   );

   // pace the result side
   always @(posedge clock) begin : drain_side
      int draw;
      if (reset) begin
         pop <= 1'b0;
         rsp_gap <= 0;
      end else if (pop && !empty) begin
         draw = quick ? 0 : $urandom_range(0, 16);
         pop <= (draw == 0) && !rsp_hold;
         rsp_gap <= draw;
      end else if (!pop) begin
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
         end else if (!rsp_hold) begin
            pop <= 1'b1;
         end
      end
   end

   // hold off the result side long enough to fill the block
   initial begin : hold_off
      wait (bytes_sent >= 120);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (400) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin : watchdog
      #5_000_000;
      $display("** json_string_escape_core: FAILED **");
      $finish;
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      int gap;
      gap = quick ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (full);
      bytes_sent++;
   endtask

   task automatic settle();
      push <= 1'b0;
      @(posedge clock);
      wait (words_owed == 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_capacity(input int unsigned cap);
      settle();
      csr_valid <= 1'b1;
      csr_capacity <= cap[CAP_W-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [BYTE_W-1:0] pick_byte();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 5) begin
         return BYTE_W'($urandom_range(0, 255));
      end else if (r < 65) begin
         return BYTE_W'($urandom_range(CTRL_LIMIT, 255));
      end else if (r < 80) begin
         return pair_chars[$urandom_range(0, 4)];
      end
      return BYTE_W'($urandom_range(1, CTRL_LIMIT - 1));
   endfunction

   task automatic send_string(input int len);
      for (int i = 0; i < len; i++) begin
         send_byte(pick_byte());
      end
      send_byte(CH_NUL);
   endtask

   initial begin : stimulus
      int unsigned caps [6];
      int          phase_start;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset capacity: plain extremes, every escape, empty string
      send_byte(8'h20);
      send_byte(8'hff);
      send_byte(8'h7f);
      send_byte(CH_QUOTE);
      send_byte(CH_BSL);
      send_byte(CH_LF);
      send_byte(CH_CR);
      send_byte(CH_TAB);
      send_byte(8'h01);
      send_byte(8'h1f);
      send_byte(CH_NUL);
      send_byte(CH_NUL);

      // smallest capacity: one byte, then stop and drop
      write_capacity(3);
      send_byte(8'h61);
      send_byte(8'h62);
      send_byte(8'h01);
      send_byte(CH_NUL);

      // six-byte escape without room
      write_capacity(6);
      send_byte(8'h01);
      send_byte(CH_NUL);

      // six-byte escape just fits, then no room
      write_capacity(7);
      send_byte(8'h01);
      send_byte(8'h78);
      send_byte(CH_NUL);

      write_capacity(4);
      send_byte(CH_QUOTE);
      send_byte(8'h7a);
      send_byte(CH_NUL);

      caps[0] = 3;
      caps[1] = $urandom_range(CAP_MAX + 1, (1 << CAP_W) - 1);
      caps[2] = $urandom_range(4, 16);
      caps[3] = $urandom_range(17, 60);
      caps[4] = $urandom_range(61, 300);
      caps[5] = CAP_RESET;

      foreach (caps[p]) begin
         write_capacity(caps[p]);
         quick = ($urandom_range(0, 3) == 0);
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < 50) begin
            send_string($urandom_range(0, 12));
         end
         quick = 1'b0;
      end

      settle();
      repeat (16) @(posedge clock);
      if (fail_count == 0 && words_owed == 0) begin
         $display("** json_string_escape_core: PASSED **");
      end else begin
         $display("** json_string_escape_core: FAILED **");
      end
      $finish;
   end

endmodule

// File: filelist.f
sv/jse_pkg.sv
sv/jse_front.sv
sv/jse_queue.sv
sv/jse_back.sv
sv/json_string_escape_core.sv
tb/sv/json_string_escape_core_checker.sv
tb/sv/json_string_escape_core_test.sv
